// ===== hw/rtl/q24_8_fixed_point_alu_assert.svh =====
// Assertion macros for the fixed-point ALU.
// Used by the top level only; needs a clk and rst in scope.
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FPA_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("fixed-point alu assertion failed");
// next-cycle implication
`define FPA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("fixed-point alu assertion failed");
`else
`define FPA_ASSERT_IMPLY(label, cond, prop)
`define FPA_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== hw/rtl/fpa_pkg.sv =====
// Shared types and constants of the fixed-point ALU.
// No dependencies.
`default_nettype none
package fpa_pkg;
  localparam int FRAC = 8;
  localparam int DIV_W = 32 + FRAC;
  localparam logic [63:0] MUL_BIAS = 64'((64'd1 << FRAC) - 64'd1);
  localparam logic [31:0] INT_BIAS = 32'((64'd1 << FRAC) - 64'd1);

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_t;

  // sideband that rides along the pipeline
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] value;
    logic        cmp;
    logic        dz;
    logic        neg;
  } side_t;

  // divider working set handed from cell to cell
  typedef struct packed {
    logic [31:0]      rem;
    logic [DIV_W-1:0] dvd;
    logic [31:0]      dsr;
  } div_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fpa_front.sv =====
// Front stages: operation decode, simple results, multiply and scaling.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  item_valid,
  input  wire  [3:0]           op,
  input  wire  signed [31:0]   left_raw,
  input  wire  signed [31:0]   right_raw,
  output fpa_pkg::side_t       side_out,
  output fpa_pkg::div_t        div_out
);
  fpa_pkg::side_t side0, side0_next, side1_next;
  fpa_pkg::div_t  div0, div0_next;
  logic signed [63:0] prod, prod_next;
  logic [63:0] prod_biased;
  logic [31:0] abs_a, abs_b, a_biased;

  // stage 0: decode and simple ops
  always_comb begin
    abs_a = left_raw[31] ? 32'(-left_raw) : left_raw;
    abs_b = right_raw[31] ? 32'(-right_raw) : right_raw;
    a_biased = left_raw[31] ? 32'(left_raw + $signed(fpa_pkg::INT_BIAS)) : left_raw;
    side0_next.valid = item_valid;
    side0_next.op = fpa_pkg::op_t'(op);
    side0_next.value = 32'd0;
    side0_next.cmp = 1'b0;
    side0_next.dz = (fpa_pkg::op_t'(op) == fpa_pkg::OP_DIV) && (right_raw == 32'sd0);
    side0_next.neg = left_raw[31] ^ right_raw[31];
    case (fpa_pkg::op_t'(op))
      fpa_pkg::OP_ADD:      side0_next.value = 32'(left_raw + right_raw);
      fpa_pkg::OP_SUB:      side0_next.value = 32'(left_raw - right_raw);
      fpa_pkg::OP_GT:       side0_next.cmp = left_raw > right_raw;
      fpa_pkg::OP_LT:       side0_next.cmp = left_raw < right_raw;
      fpa_pkg::OP_GE:       side0_next.cmp = left_raw >= right_raw;
      fpa_pkg::OP_LE:       side0_next.cmp = left_raw <= right_raw;
      fpa_pkg::OP_EQ:       side0_next.cmp = left_raw == right_raw;
      fpa_pkg::OP_NE:       side0_next.cmp = left_raw != right_raw;
      fpa_pkg::OP_MIN:      side0_next.value = (left_raw < right_raw) ? left_raw : right_raw;
      fpa_pkg::OP_MAX:      side0_next.value = (left_raw < right_raw) ? right_raw : left_raw;
      fpa_pkg::OP_INC:      side0_next.value = 32'(left_raw + 32'sd1);
      fpa_pkg::OP_DEC:      side0_next.value = 32'(left_raw - 32'sd1);
      fpa_pkg::OP_TO_INT:   side0_next.value = 32'($signed(a_biased) >>> fpa_pkg::FRAC);
      fpa_pkg::OP_FROM_INT: side0_next.value = 32'(left_raw << fpa_pkg::FRAC);
      default:              side0_next.value = 32'd0;
    endcase
    prod_next = left_raw * right_raw;
    div0_next.rem = 32'd0;
    div0_next.dvd = fpa_pkg::DIV_W'(abs_a) << fpa_pkg::FRAC;
    div0_next.dsr = abs_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side0.valid <= 1'b0;
    end else if (en) begin
      side0 <= side0_next;
    end
    if (en) begin
      prod <= prod_next;
      div0 <= div0_next;
    end
  end

  // stage 1: scale product toward zero
  always_comb begin
    prod_biased = prod[63] ? 64'(prod + $signed(fpa_pkg::MUL_BIAS)) : prod;
    side1_next = side0;
    if (side0.op == fpa_pkg::OP_MUL) begin
      side1_next.value = 32'($signed(prod_biased) >>> fpa_pkg::FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side1_next;
    end
    if (en) begin
      div_out <= div0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fpa_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per beat.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire fpa_pkg::side_t  side_in,
  input  wire fpa_pkg::div_t   div_in,
  output fpa_pkg::side_t       side_out,
  output fpa_pkg::div_t        div_out
);
  fpa_pkg::div_t div_next;
  logic [32:0] trial;
  logic        qbit;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {div_in.rem, div_in.dvd[fpa_pkg::DIV_W-1]};
    qbit = trial >= {1'b0, div_in.dsr};
    div_next.dsr = div_in.dsr;
    div_next.rem = qbit ? 32'(trial - {1'b0, div_in.dsr}) : trial[31:0];
    div_next.dvd = {div_in.dvd[fpa_pkg::DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      div_out <= div_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/q24_8_fixed_point_alu.sv =====
// Q24.8 fixed-point ALU top level: input skid, front stages, divider cell row, output.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, q24_8_fixed_point_alu_assert.svh.
//
// One item is accepted per cycle while item_stall is low, and every item yields one result;
// from the accepting edge to the edge that raises result_valid it passes through the decode
// register (loaded at the accepting edge), the 32x32 product and scaling register, one
// divider cell per quotient bit of the 40-bit scaled dividend, and the output register.
// All operations take that same path. A stalled result freezes the pipeline; a one-entry
// input skid keeps item_stall registered, and a beat caught in it is taken from the skid
// once the pipeline runs again.
`default_nettype none
`include "q24_8_fixed_point_alu_assert.svh"
module q24_8_fixed_point_alu (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire  [3:0]          op,
  input  wire  signed [31:0]  left_raw,
  input  wire  signed [31:0]  right_raw,
  output logic                result_valid,
  input  wire                 result_stall,
  output logic signed [31:0]  value,
  output logic                compare_true,
  output logic                divide_by_zero
);
  logic en;
  logic skid_full;
  logic [3:0] skid_op;
  logic signed [31:0] skid_a, skid_b;
  logic take_valid;
  logic [3:0] take_op;
  logic signed [31:0] take_a, take_b;
  fpa_pkg::side_t side_c [0:fpa_pkg::DIV_W];
  fpa_pkg::div_t  div_c  [0:fpa_pkg::DIV_W];
  fpa_pkg::side_t last;
  logic [31:0] quo;

  assign en = !(result_valid && result_stall);
  assign item_stall = skid_full;

  // input skid: holds one beat caught while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (item_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
    if (!en && item_valid && !skid_full) begin
      skid_op <= op;
      skid_a <= left_raw;
      skid_b <= right_raw;
    end
  end

  assign take_valid = skid_full || item_valid;
  assign take_op = skid_full ? skid_op : op;
  assign take_a = skid_full ? skid_a : left_raw;
  assign take_b = skid_full ? skid_b : right_raw;

  fpa_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .item_valid(take_valid), .op(take_op), .left_raw(take_a), .right_raw(take_b),
    .side_out(side_c[0]), .div_out(div_c[0])
  );

  // row of divider cells
  for (genvar i = 0; i < fpa_pkg::DIV_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .side_in(side_c[i]), .div_in(div_c[i]),
      .side_out(side_c[i+1]), .div_out(div_c[i+1])
    );
  end

  assign last = side_c[fpa_pkg::DIV_W];
  assign quo = div_c[fpa_pkg::DIV_W].dvd[31:0];

  // output register: apply divide sign and zero-divisor case
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.valid;
    end
    if (en) begin
      compare_true <= last.cmp;
      divide_by_zero <= last.dz;
      if (last.op == fpa_pkg::OP_DIV) begin
        value <= last.dz ? 32'sd0 : (last.neg ? $signed(32'(-quo)) : $signed(quo));
      end else begin
        value <= last.value;
      end
    end
  end

  `FPA_ASSERT_IMPLY(a_dz_zero, result_valid && divide_by_zero, value == 32'sd0 && !compare_true)
  `FPA_ASSERT_NEXT(a_skid_hold, skid_full && !en, skid_full)
  `FPA_ASSERT_NEXT(a_skid_fill, item_valid && !item_stall && !en, skid_full)
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the Q24.8 fixed-point ALU: directed and random operand beats,
// bursty sender, stalling receiver, in-order result checking. Depends on fpa_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int LATENCY = 43;
  localparam int RANDOM_BEATS = 1350;

  typedef struct packed {
    op_t         op;
    logic [31:0] left;
    logic [31:0] right;
  } alu_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [3:0] op = '0;
  logic signed [31:0] left_raw = '0;
  logic signed [31:0] right_raw = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] value;
  logic compare_true;
  logic divide_by_zero;

  alu_beat_t   pending_beats[$];
  alu_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  bit stimulus_done = 1'b0;
  bit hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  q24_8_fixed_point_alu i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .left_raw(left_raw), .right_raw(right_raw),
    .result_valid(result_valid), .result_stall(result_stall),
    .value(value), .compare_true(compare_true), .divide_by_zero(divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predict the result of one beat
  function automatic alu_result_t alu_predict(alu_beat_t b);
    alu_result_t r;
    longint a;
    longint c;
    longint v;
    a = longint'(signed'(b.left));
    c = longint'(signed'(b.right));
    v = 0;
    r = '0;
    case (b.op)
      OP_ADD: v = a + c;
      OP_SUB: v = a - c;
      OP_MUL: v = (a * c) / 256;
      OP_DIV: begin
        if (c == 0) r.dz = 1'b1;
        else v = (a * 256) / c;
      end
      OP_GT: r.cmp = a > c;
      OP_LT: r.cmp = a < c;
      OP_GE: r.cmp = a >= c;
      OP_LE: r.cmp = a <= c;
      OP_EQ: r.cmp = a == c;
      OP_NE: r.cmp = a != c;
      OP_MIN: v = (a < c) ? a : c;
      OP_MAX: v = (a < c) ? c : a;
      OP_INC: v = a + 1;
      OP_DEC: v = a - 1;
      OP_TO_INT: v = a / 256;
      default: v = a * 256;
    endcase
    r.value = v[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s at result %0d: got %h, expected %h",
             $realtime, what, results_seen, got, want);
    errors++;
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 1024)) - 512);
      3: return 32'($urandom_range(0, 4)) << 8;
      4: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_beat(op_t o, logic [31:0] l, logic [31:0] r);
    pending_beats.push_back('{op: o, left: l, right: r});
  endtask

  // Driver: bursts with random gaps; payload holds while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(alu_predict('{op: op_t'(op), left: left_raw,
                                                 right: right_raw}));
        beats_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending_beats.size() > 0 && !hold_sender) begin
          alu_beat_t b;
          b = pending_beats.pop_front();
          op <= b.op;
          left_raw <= b.left;
          right_raw <= b.right;
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with nothing expected", $realtime);
          errors++;
        end else begin
          alu_result_t w;
          w = expected_results.pop_front();
          if (value !== w.value) report_mismatch("value", value, w.value);
          if (compare_true !== w.cmp)
            report_mismatch("compare_true", 32'(compare_true), 32'(w.cmp));
          if (divide_by_zero !== w.dz)
            report_mismatch("divide_by_zero", 32'(divide_by_zero), 32'(w.dz));
        end
        results_seen++;
      end
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 150) result_stall <= 1'b0;
      else if (stall_phase < 300) result_stall <= ($urandom_range(0, 3) == 0);
      else if (stall_phase < 450) result_stall <= ($urandom_range(0, 1) == 0);
      else result_stall <= ($urandom_range(0, 9) == 0);
    end
  end

  // Stimulus and end of run
  initial begin
    op_t o;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation at the operand extremes, plus divide by zero and other corner cases
    for (int k = 0; k < 16; k++) begin
      o = op_t'(k);
      add_beat(o, 32'h7fff_ffff, 32'h8000_0000);
    end
    add_beat(OP_DIV, 32'h0000_0100, 32'h0);
    add_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    add_beat(OP_MUL, 32'hffff_ff01, 32'h0000_0080);
    add_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);
    add_beat(OP_EQ, 32'h1234_5678, 32'h1234_5678);
    add_beat(OP_INC, 32'h7fff_ffff, 32'h0);
    add_beat(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
    add_beat(OP_FROM_INT, 32'h0080_0000, 32'h0);

    // Random part, with one pause until the pipeline has drained
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      logic [31:0] l;
      logic [31:0] r;
      o = op_t'($urandom_range(0, 15));
      l = random_operand();
      r = ($urandom_range(0, 3) == 0) ? l : random_operand();
      add_beat(o, l, r);
      if (n == RANDOM_BEATS / 2) begin
        wait (pending_beats.size() == 0);
        hold_sender = 1'b1;
        @(posedge clk);
        wait (!item_valid);
        wait (expected_results.size() == 0);
        repeat (2) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (pending_beats.size() == 0);
    @(posedge clk);
    wait (!item_valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    stimulus_done = 1'b1;
    $display("Covered %0d beats over all 16 operations, %0d results checked.",
             beats_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Watchdog expired with %0d results outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule
